/* rtl/gcfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcfr_pkg
// Types and constants shared by the glyph cache tag engine.
// ----------------------------------------------------------------------------
package gcfr_pkg;

  localparam int CodeBits    = 16;
  localparam int CodeSpace   = 1 << CodeBits;
  localparam int BlkBits     = 8;
  localparam int NumBlocks   = 1 << BlkBits;
  localparam int SizeBits    = 8;
  localparam int UseBits     = 9;
  localparam int MetricsBits = 32;

  localparam logic [UseBits-1:0] DefBlocksInUse = 9'd256;
  localparam logic [SizeBits-1:0] DefMaxSize   = 8'd32;

  localparam logic [7:0] CfgMaxGlyphSize = 8'd0;
  localparam logic [7:0] CfgBlocksInUse  = 8'd1;

  localparam logic [1:0] StatusHit     = 2'd0;
  localparam logic [1:0] StatusMiss    = 2'd1;
  localparam logic [1:0] StatusStored  = 2'd2;
  localparam logic [1:0] StatusRefused = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_IDX,
    S_RD_TAG,
    S_WR_TAG,
    S_WR_OLD,
    S_WR_SET,
    S_REFUSE
  } gcfr_state_e;

  typedef struct packed {
    logic               valid;
    logic [BlkBits-1:0] blk;
  } idx_entry_t;

  typedef struct packed {
    logic [MetricsBits-1:0] metrics;
    logic [7:0]             style;
    logic [SizeBits-1:0]    size;
    logic [7:0]             font;
    logic [CodeBits-1:0]    code;
  } blk_word_t;

  typedef struct packed {
    logic                   func;
    logic [CodeBits-1:0]    code;
    logic [7:0]             font;
    logic [SizeBits-1:0]    size;
    logic [7:0]             style;
    logic [MetricsBits-1:0] metrics;
  } req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [BlkBits-1:0]     slot;
    logic [MetricsBits-1:0] metrics;
  } rsp_t;

  typedef struct packed {
    logic                re;
    logic                we;
    logic [CodeBits-1:0] addr;
    idx_entry_t          wdata;
  } idx_port_t;

  typedef struct packed {
    logic               re;
    logic               we;
    logic [BlkBits-1:0] raddr;
    logic [BlkBits-1:0] waddr;
    blk_word_t          wdata;
  } blk_port_t;

endpackage

/* rtl/gcfr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcfr_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gcfr_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/gcfr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcfr_ctrl
// Lookup / insert sequencer: walks the code index and block tag memories,
// keeps tag valid bits and the round-robin victim pointer.
// ----------------------------------------------------------------------------
module gcfr_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  gcfr_pkg::req_t                 in_req_i,
  input  logic [gcfr_pkg::SizeBits-1:0]  max_size_i,
  input  logic [gcfr_pkg::UseBits-1:0]   blocks_i,
  output gcfr_pkg::idx_port_t            idx_port_o,
  input  gcfr_pkg::idx_entry_t           idx_rdata_i,
  output gcfr_pkg::blk_port_t            blk_port_o,
  input  gcfr_pkg::blk_word_t            blk_rdata_i,
  output logic                           rsp_valid_o,
  input  logic                           rsp_ready_i,
  output gcfr_pkg::rsp_t                 rsp_o
);

  import gcfr_pkg::*;

  gcfr_state_e              state_q, state_d;
  req_t                     req_q, req_d;
  logic [BlkBits-1:0]       victim_q, victim_d;
  logic [NumBlocks-1:0]     tag_vld_q, tag_vld_d;
  logic [CodeBits-1:0]      clr_addr_q, clr_addr_d;

  logic                     accept;
  logic                     too_big;
  logic                     tag_match;
  logic [UseBits-1:0]       rot_len;
  logic [UseBits-1:0]       victim_inc;
  logic [BlkBits-1:0]       victim_next;

  assign accept  = in_valid_i && (state_q == S_IDLE);
  assign too_big = in_req_i.size > max_size_i;

  assign tag_match = tag_vld_q[idx_rdata_i.blk] &&
                     (blk_rdata_i.code  == req_q.code) &&
                     (blk_rdata_i.font  == req_q.font) &&
                     (blk_rdata_i.size  == req_q.size) &&
                     (blk_rdata_i.style == req_q.style);

  // rotation length: zero acts as one, saturated at the pool size
  always_comb begin
    rot_len = blocks_i;
    if (blocks_i == '0) begin
      rot_len = UseBits'(1);
    end else if (blocks_i > UseBits'(NumBlocks)) begin
      rot_len = UseBits'(NumBlocks);
    end
  end

  assign victim_inc  = {1'b0, victim_q} + UseBits'(1);
  assign victim_next = (victim_inc >= rot_len) ? '0 : victim_inc[BlkBits-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (&clr_addr_q) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (!in_req_i.func) state_d = S_RD_IDX;
          else if (too_big)   state_d = S_REFUSE;
          else                state_d = S_WR_TAG;
        end
      end
      S_RD_IDX: begin
        if (idx_rdata_i.valid) state_d = S_RD_TAG;
        else if (rsp_ready_i)  state_d = S_IDLE;
      end
      S_RD_TAG: begin
        if (rsp_ready_i) state_d = S_IDLE;
      end
      S_WR_TAG: begin
        state_d = tag_vld_q[victim_q] ? S_WR_OLD : S_WR_SET;
      end
      S_WR_OLD: begin
        state_d = S_WR_SET;
      end
      S_WR_SET: begin
        if (rsp_ready_i) state_d = S_IDLE;
      end
      S_REFUSE: begin
        if (rsp_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready_o  = (state_q == S_IDLE);
    idx_port_o  = '0;
    blk_port_o  = '0;
    rsp_valid_o = 1'b0;
    rsp_o       = '0;
    req_d       = accept ? in_req_i : req_q;
    victim_d    = victim_q;
    tag_vld_d   = tag_vld_q;
    clr_addr_d  = clr_addr_q;
    case (state_q)
      S_CLEAR: begin
        idx_port_o.we   = 1'b1;
        idx_port_o.addr = clr_addr_q;
        clr_addr_d      = clr_addr_q + CodeBits'(1);
      end
      S_IDLE: begin
        idx_port_o.re    = in_valid_i && !in_req_i.func;
        idx_port_o.addr  = in_req_i.code;
        blk_port_o.re    = in_valid_i && in_req_i.func && !too_big;
        blk_port_o.raddr = victim_q;
      end
      S_RD_IDX: begin
        if (idx_rdata_i.valid) begin
          blk_port_o.re    = 1'b1;
          blk_port_o.raddr = idx_rdata_i.blk;
        end else begin
          rsp_valid_o   = 1'b1;
          rsp_o.status  = StatusMiss;
        end
      end
      S_RD_TAG: begin
        rsp_valid_o = 1'b1;
        if (tag_match) begin
          rsp_o.status  = StatusHit;
          rsp_o.slot    = idx_rdata_i.blk;
          rsp_o.metrics = blk_rdata_i.metrics;
        end else begin
          rsp_o.status  = StatusMiss;
        end
      end
      S_WR_TAG: begin
        blk_port_o.we            = 1'b1;
        blk_port_o.waddr         = victim_q;
        blk_port_o.wdata.code    = req_q.code;
        blk_port_o.wdata.font    = req_q.font;
        blk_port_o.wdata.size    = req_q.size;
        blk_port_o.wdata.style   = req_q.style;
        blk_port_o.wdata.metrics = req_q.metrics;
        tag_vld_d[victim_q]      = 1'b1;
        idx_port_o.re            = tag_vld_q[victim_q];
        idx_port_o.addr          = blk_rdata_i.code;
      end
      S_WR_OLD: begin
        // drop the old code's entry only if it still names the victim
        idx_port_o.we   = idx_rdata_i.valid && (idx_rdata_i.blk == victim_q);
        idx_port_o.addr = blk_rdata_i.code;
      end
      S_WR_SET: begin
        rsp_valid_o            = 1'b1;
        rsp_o.status           = StatusStored;
        rsp_o.slot             = victim_q;
        idx_port_o.we          = rsp_ready_i;
        idx_port_o.addr        = req_q.code;
        idx_port_o.wdata.valid = 1'b1;
        idx_port_o.wdata.blk   = victim_q;
        if (rsp_ready_i) victim_d = victim_next;
      end
      S_REFUSE: begin
        rsp_valid_o  = 1'b1;
        rsp_o.status = StatusRefused;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      victim_q   <= '0;
      tag_vld_q  <= '0;
      clr_addr_q <= '0;
    end else begin
      state_q    <= state_d;
      victim_q   <= victim_d;
      tag_vld_q  <= tag_vld_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

endmodule

/* rtl/glyph_cache_fifo_replace_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_cache_fifo_replace_top
// Glyph cache tag engine: direct-indexed code table over a pool of 256
// blocks with round-robin replacement.
//
// Requests enter on s_axis (tuser = func: 0 lookup, 1 insert), results leave
// on m_axis (tuser = status). One result beat per request beat, in order.
// Register writes arrive on the cfg channel (index 0 max glyph size,
// index 1 blocks in use) and are always taken; write them only when idle.
// One request is in flight at a time; a refused insert answers at once, and
// the next request is taken once the result is registered. The order of steps
// is set by the single index memory port: a lookup reads the index, then the
// tag if the entry is valid; an insert reads the victim tag, then, if that
// block was in use, reads the old index entry and clears it if it still names
// the victim, then writes the new one.
// After reset the code index is swept clear, one entry per cycle, over all
// 65536 entries; s_axis_tready stays low during the sweep. The result sits in an
// output register, so a new request is taken while it waits; if m_axis
// stalls, the engine holds at its result step until the register frees.
// ----------------------------------------------------------------------------
module glyph_cache_fifo_replace_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // code[15:0] font_id[23:16] glyph_size[31:24]
                                     // style[39:32] metrics[71:40]
  input  logic [0:0]  s_axis_tuser,  // func[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // slot[7:0] metrics_out[39:8]
  output logic [1:0]  m_axis_tuser,  // status[1:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i
);

  import gcfr_pkg::*;

  req_t                  in_req;
  logic [SizeBits-1:0]   max_size_q;
  logic [UseBits-1:0]    blocks_q;
  idx_port_t             idx_port;
  blk_port_t             blk_port;
  logic [$bits(idx_entry_t)-1:0] idx_rdata_raw;
  logic [$bits(blk_word_t)-1:0]  blk_rdata_raw;
  logic                  rsp_valid;
  logic                  rsp_ready;
  rsp_t                  rsp;
  logic                  out_valid_q;
  rsp_t                  out_q;

  assign in_req.func    = s_axis_tuser[0];
  assign in_req.code    = s_axis_tdata[15:0];
  assign in_req.font    = s_axis_tdata[23:16];
  assign in_req.size    = s_axis_tdata[31:24];
  assign in_req.style   = s_axis_tdata[39:32];
  assign in_req.metrics = s_axis_tdata[71:40];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_size_q <= DefMaxSize;
      blocks_q   <= DefBlocksInUse;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgMaxGlyphSize) max_size_q <= cfg_data_i[SizeBits-1:0];
      if (cfg_index_i == CfgBlocksInUse)  blocks_q   <= cfg_data_i[UseBits-1:0];
    end
  end

  gcfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_req_i    (in_req),
    .max_size_i  (max_size_q),
    .blocks_i    (blocks_q),
    .idx_port_o  (idx_port),
    .idx_rdata_i (idx_entry_t'(idx_rdata_raw)),
    .blk_port_o  (blk_port),
    .blk_rdata_i (blk_word_t'(blk_rdata_raw)),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp)
  );

  gcfr_ram #(
    .Width ($bits(idx_entry_t)),
    .Depth (CodeSpace)
  ) u_idx_ram (
    .clk_i   (clk_i),
    .we_i    (idx_port.we),
    .waddr_i (idx_port.addr),
    .wdata_i (idx_port.wdata),
    .re_i    (idx_port.re),
    .raddr_i (idx_port.addr),
    .rdata_o (idx_rdata_raw)
  );

  gcfr_ram #(
    .Width ($bits(blk_word_t)),
    .Depth (NumBlocks)
  ) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (blk_port.we),
    .waddr_i (blk_port.waddr),
    .wdata_i (blk_port.wdata),
    .re_i    (blk_port.re),
    .raddr_i (blk_port.raddr),
    .rdata_o (blk_rdata_raw)
  );

  assign rsp_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_ready) begin
      out_valid_q <= rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_valid && rsp_ready) begin
      out_q <= rsp;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.metrics, out_q.slot};
  assign m_axis_tuser  = out_q.status;

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the glyph cache tag engine. A driver feeds lookup
// and insert beats from a queue, a monitor checks each result beat against
// an in-bench model of the index table, block tags and round-robin victim
// pointer. Phases vary the max size and rotation registers and the idling
// of both stream sides.
// ----------------------------------------------------------------------------
module tb;
  import gcfr_pkg::*;

  localparam int QuietLimit = 200000;
  localparam int DrainCycles = 8;

  typedef struct packed {
    logic [7:0] idx;
    logic [8:0] data;
  } reg_wr_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [8:0]  cfg_data_i = '0;

  glyph_cache_fifo_replace_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // stimulus queues and result store
  req_t    req_q[$];
  reg_wr_t cfg_q[$];
  rsp_t    pending_rsp_q[$];
  req_t    seen_q[$];

  int unsigned src_gap_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned gen_max = 32;
  int unsigned err_cnt = 0;
  int unsigned quiet_cycles = 0;
  req_t        beat_req = '0;

  // cache model state
  bit                 idx_vld  [CodeSpace];
  bit [BlkBits-1:0]   idx_blk  [CodeSpace];
  bit                 tag_vld  [NumBlocks];
  bit [CodeBits-1:0]  tag_code [NumBlocks];
  bit [7:0]           tag_font [NumBlocks];
  bit [SizeBits-1:0]  tag_size [NumBlocks];
  bit [7:0]           tag_style[NumBlocks];
  bit [MetricsBits-1:0] blk_metrics[NumBlocks];
  bit [SizeBits-1:0]  max_size = DefMaxSize;
  bit [UseBits-1:0]   blocks_cfg = DefBlocksInUse;
  int unsigned        victim = 0;

  function automatic rsp_t cache_step(req_t r);
    rsp_t o;
    int unsigned b;
    int unsigned n;
    int unsigned v;
    bit [CodeBits-1:0] old;
    o.status  = StatusMiss;
    o.slot    = '0;
    o.metrics = '0;
    if (!r.func) begin
      if (idx_vld[r.code]) begin
        b = idx_blk[r.code];
        if (tag_vld[b] && tag_code[b] == r.code && tag_font[b] == r.font &&
            tag_size[b] == r.size && tag_style[b] == r.style) begin
          o.status  = StatusHit;
          o.slot    = b[BlkBits-1:0];
          o.metrics = blk_metrics[b];
        end
      end
    end else if (r.size > max_size) begin
      o.status = StatusRefused;
    end else begin
      v = victim % NumBlocks;
      n = (blocks_cfg == 0) ? 1 : (blocks_cfg > NumBlocks) ? NumBlocks : blocks_cfg;
      if (tag_vld[v]) begin
        old = tag_code[v];
        if (idx_vld[old] && idx_blk[old] == v[BlkBits-1:0]) idx_vld[old] = 1'b0;
      end
      tag_vld[v]     = 1'b1;
      tag_code[v]    = r.code;
      tag_font[v]    = r.font;
      tag_size[v]    = r.size;
      tag_style[v]   = r.style;
      blk_metrics[v] = r.metrics;
      idx_vld[r.code] = 1'b1;
      idx_blk[r.code] = v[BlkBits-1:0];
      victim   = (v + 1 >= n) ? 0 : v + 1;
      o.status = StatusStored;
      o.slot   = v[BlkBits-1:0];
    end
    return o;
  endfunction

  // driver: register writes first, requests only with the config channel quiet
  always @(posedge clk_i or negedge rst_ni) begin : drv
    reg_wr_t w;
    req_t    r;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      cfg_valid_i   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgMaxGlyphSize) max_size = cfg_data_i[SizeBits-1:0];
        else if (cfg_index_i == CfgBlocksInUse) blocks_cfg = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) pending_rsp_q.push_back(cache_step(beat_req));

      if (!cfg_valid_i || cfg_ready_o) begin
        if (cfg_q.size() > 0) begin
          w = cfg_q.pop_front();
          cfg_index_i <= w.idx;
          cfg_data_i  <= w.data;
          cfg_valid_i <= 1'b1;
        end else begin
          cfg_valid_i <= 1'b0;
        end
      end

      if (!s_axis_tvalid || s_axis_tready) begin
        if (req_q.size() > 0 && cfg_q.size() == 0 && !cfg_valid_i &&
            $urandom_range(99) >= src_gap_pct) begin
          r = req_q.pop_front();
          beat_req      <= r;
          s_axis_tdata  <= {r.metrics, r.style, r.size, r.font, r.code};
          s_axis_tuser  <= r.func;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin : mon
    rsp_t got;
    rsp_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status  = m_axis_tuser;
        got.slot    = m_axis_tdata[7:0];
        got.metrics = m_axis_tdata[39:8];
        if (pending_rsp_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("tb: unexpected result status %0d slot %0d metrics %h",
                     got.status, got.slot, got.metrics);
        end else begin
          want = pending_rsp_q.pop_front();
          if (got !== want) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("tb: mismatch exp status %0d slot %0d metrics %h, got %0d %0d %h",
                       want.status, want.slot, want.metrics,
                       got.status, got.slot, got.metrics);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // watchdog: covers the index sweep after reset
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                 (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_req(bit func, bit [15:0] code, bit [7:0] font, bit [7:0] size,
                          bit [7:0] style, bit [31:0] metrics);
    req_t r;
    r.func    = func;
    r.code    = code;
    r.font    = font;
    r.size    = size;
    r.style   = style;
    r.metrics = metrics;
    req_q.push_back(r);
  endtask

  task automatic set_reg(bit [7:0] idx, bit [8:0] data);
    reg_wr_t w;
    w.idx  = idx;
    w.data = data;
    cfg_q.push_back(w);
    if (idx == CfgMaxGlyphSize) gen_max = data[7:0];
    while (cfg_q.size() != 0 || cfg_valid_i) @(negedge clk_i);
  endtask

  task automatic settle();
    while (req_q.size() != 0 || s_axis_tvalid || pending_rsp_q.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // mostly small code pool and replays of inserted tags so lookups hit
  task automatic gen_random(int n);
    req_t r;
    req_t h;
    repeat (n) begin
      r.func    = ($urandom_range(99) < 45);
      r.metrics = $urandom();
      if (!r.func && seen_q.size() > 0 && $urandom_range(99) < 70) begin
        h = seen_q[$urandom_range(seen_q.size() - 1)];
        r.code  = h.code;
        r.font  = h.font;
        r.size  = h.size;
        r.style = h.style;
        case ($urandom_range(9))
          0: r.font  ^= 8'(1 << $urandom_range(7));
          1: r.size  ^= 8'(1 << $urandom_range(7));
          2: r.style ^= 8'(1 << $urandom_range(7));
          3: r.code  ^= 16'(1 << $urandom_range(15));
          default: ;
        endcase
      end else begin
        r.code  = ($urandom_range(99) < 70) ? 16'($urandom_range(31)) : 16'($urandom());
        r.font  = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom());
        r.style = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom());
        r.size  = ($urandom_range(99) < 80) ? 8'($urandom_range(gen_max)) : 8'($urandom());
        if (r.func) begin
          seen_q.push_back(r);
          if (seen_q.size() > 48) void'(seen_q.pop_front());
        end
      end
      req_q.push_back(r);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset config, no idling
    push_req(1'b0, 16'h0000, 8'h00, 8'h00, 8'h00, 32'h0);
    push_req(1'b0, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFFFFFF);
    push_req(1'b1, 16'hFFFF, 8'hFF, 8'd32, 8'hFF, 32'hFFFFFFFF);
    push_req(1'b0, 16'hFFFF, 8'hFF, 8'd32, 8'hFF, 32'h0);
    push_req(1'b0, 16'hFFFF, 8'hFE, 8'd32, 8'hFF, 32'h0);
    push_req(1'b0, 16'hFFFF, 8'hFF, 8'd31, 8'hFF, 32'h0);
    push_req(1'b0, 16'hFFFF, 8'hFF, 8'd32, 8'hFE, 32'h0);
    push_req(1'b1, 16'h1234, 8'h01, 8'd33, 8'h00, 32'h1);
    push_req(1'b1, 16'h1234, 8'h01, 8'hFF, 8'h00, 32'h1);
    push_req(1'b1, 16'h0000, 8'h00, 8'h00, 8'h00, 32'h0);
    push_req(1'b0, 16'h0000, 8'h00, 8'h00, 8'h00, 32'hFFFFFFFF);
    push_req(1'b1, 16'hFFFF, 8'hFF, 8'd32, 8'hFF, 32'h5A5AA5A5);
    push_req(1'b0, 16'hFFFF, 8'hFF, 8'd32, 8'hFF, 32'h0);
    push_req(1'b1, 16'hAAAA, 8'h55, 8'd21, 8'hAA, 32'hAAAAAAAA);
    push_req(1'b1, 16'h5555, 8'hAA, 8'd10, 8'h55, 32'h55555555);
    push_req(1'b0, 16'hAAAA, 8'h55, 8'd21, 8'hAA, 32'h0);
    push_req(1'b0, 16'h5555, 8'hAA, 8'd10, 8'h55, 32'h0);
    gen_random(110);
    settle();

    // shrink rotation below the victim pointer; duplicate code survives eviction
    src_gap_pct = 79;
    set_reg(CfgMaxGlyphSize, 9'd255);
    set_reg(CfgBlocksInUse, 9'd4);
    gen_max = 255;
    push_req(1'b1, 16'h0100, 8'h01, 8'hFF, 8'h01, 32'h11111111);
    push_req(1'b1, 16'h0777, 8'h07, 8'd7, 8'h07, 32'h77770000);
    push_req(1'b1, 16'h0777, 8'h07, 8'd7, 8'h07, 32'h77770001);
    push_req(1'b1, 16'h0101, 8'h01, 8'd1, 8'h01, 32'h1);
    push_req(1'b1, 16'h0102, 8'h01, 8'd2, 8'h01, 32'h2);
    push_req(1'b1, 16'h0103, 8'h01, 8'd3, 8'h01, 32'h3);
    push_req(1'b0, 16'h0777, 8'h07, 8'd7, 8'h07, 32'h0);
    gen_random(130);
    settle();

    // single block, max size of one
    src_gap_pct   = 0;
    snk_stall_pct = 79;
    set_reg(CfgMaxGlyphSize, 9'd1);
    set_reg(CfgBlocksInUse, 9'd1);
    push_req(1'b1, 16'h0020, 8'h02, 8'd1, 8'h02, 32'hA);
    push_req(1'b1, 16'h0021, 8'h02, 8'd0, 8'h02, 32'hB);
    push_req(1'b0, 16'h0020, 8'h02, 8'd1, 8'h02, 32'h0);
    push_req(1'b0, 16'h0021, 8'h02, 8'd0, 8'h02, 32'h0);
    gen_random(100);
    settle();

    // zero blocks in use acts as one
    src_gap_pct   = 32;
    snk_stall_pct = 32;
    set_reg(CfgMaxGlyphSize, 9'd200);
    set_reg(CfgBlocksInUse, 9'd0);
    gen_random(90);
    settle();

    // oversized rotation saturates to the pool
    src_gap_pct   = 0;
    snk_stall_pct = 0;
    set_reg(CfgMaxGlyphSize, 9'd32);
    set_reg(CfgBlocksInUse, 9'd400);
    gen_random(120);
    settle();

    repeat (20) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

/* glyph_cache_fifo_replace_top.f */
rtl/gcfr_pkg.sv
rtl/gcfr_ram.sv
rtl/gcfr_ctrl.sv
rtl/glyph_cache_fifo_replace_top.sv
sim/tb.sv
